@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
// Each use expects clk and arst_n in the scope of the asserting module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define DSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define DSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/dsf_pkg.sv @@
// Package of the display serial frame deframer: widths, protocol codes,
// frame descriptor types and the classifier. No dependencies.
`default_nettype none

package dsf_pkg;

	localparam int FRAME_BYTES_DEF = 64;
	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 6;
	localparam int END_RUN         = 3;

	localparam logic [BYTE_W-1:0] END_BYTE     = 8'hFF;
	localparam logic [BYTE_W-1:0] CODE_ACK_OK  = 8'h01;
	localparam logic [BYTE_W-1:0] CODE_TOUCH   = 8'h65;
	localparam logic [BYTE_W-1:0] CODE_PAGE    = 8'h66;
	localparam logic [BYTE_W-1:0] CODE_STRING  = 8'h70;
	localparam logic [BYTE_W-1:0] CODE_NUMERIC = 8'h71;

	localparam logic [LEN_W-1:0] TOUCH_MIN_LEN = 6'd4;
	localparam logic [LEN_W-1:0] PAGE_MIN_LEN  = 6'd2;
	localparam logic [LEN_W-1:0] NUMERIC_LEN   = 6'd5;
	localparam logic [LEN_W-1:0] EVENT_LEN     = 6'd1;

	typedef enum logic [2:0] {
		KIND_ACK     = 3'd0,
		KIND_TOUCH   = 3'd1,
		KIND_PAGE    = 3'd2,
		KIND_NUMERIC = 3'd3,
		KIND_STRING  = 3'd4,
		KIND_EVENT   = 3'd5,
		KIND_UNKNOWN = 3'd6
	} frame_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} back_state_t;

	// One completed frame handed from the front to the back.
	typedef struct packed {
		logic              bank;
		logic [BYTE_W-1:0] code;
		frame_kind_t       kind;
		logic [LEN_W-1:0]  dlen;
		logic              ack_ok;
	} frame_desc_t;

	// Back tells the front that a buffer bank is free again.
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	function automatic logic is_response_code(input logic [BYTE_W-1:0] c);
		logic r;
		unique case (c)
			8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h09,
			8'h11, 8'h12, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
			8'h20, 8'h23, 8'h24: r = 1'b1;
			default:             r = 1'b0;
		endcase
		return r;
	endfunction

	// plen counts the code byte
	function automatic frame_kind_t classify(input logic [BYTE_W-1:0] c,
	                                         input logic [LEN_W-1:0] plen);
		frame_kind_t k;
		priority if (is_response_code(c))                     k = KIND_ACK;
		else if (c == CODE_TOUCH && plen >= TOUCH_MIN_LEN)    k = KIND_TOUCH;
		else if (c == CODE_PAGE && plen >= PAGE_MIN_LEN)      k = KIND_PAGE;
		else if (c == CODE_NUMERIC && plen == NUMERIC_LEN)    k = KIND_NUMERIC;
		else if (c == CODE_STRING)                            k = KIND_STRING;
		else if (plen == EVENT_LEN)                           k = KIND_EVENT;
		else                                                  k = KIND_UNKNOWN;
		return k;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/dsf_rx_if.sv @@
// Receive byte channel of the deframer: valid/ready plus one serial byte.
// Depends on nothing.
`default_nettype none

interface dsf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dsf_res_if.sv @@
// Result channel of the deframer: valid/ready plus one decoded data byte.
// Depends on dsf_pkg for the frame kind type.
`default_nettype none

interface dsf_res_if;
	logic                valid;
	logic                ready;
	logic [7:0]          frame_code;
	dsf_pkg::frame_kind_t frame_kind;
	logic [5:0]          payload_length;
	logic [7:0]          data_byte;
	logic [5:0]          data_index;
	logic                data_valid;
	logic                ack_success;
	logic                last;

	modport source (output valid, output frame_code, output frame_kind,
	                output payload_length, output data_byte, output data_index,
	                output data_valid, output ack_success, output last, input ready);
	modport sink (input valid, input frame_code, input frame_kind,
	              input payload_length, input data_byte, input data_index,
	              input data_valid, input ack_success, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dsf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered data. No dependencies.
`default_nettype none

module dsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/dsf_front.sv @@
// Front end: accepts received bytes, writes them into the ping-pong frame
// buffer, finds the terminator, classifies the frame. Uses dsf_pkg.
`default_nettype none
`include "assert_macros.svh"

module dsf_front #(
	parameter int FRAME_BYTES = dsf_pkg::FRAME_BYTES_DEF,
	localparam int IW         = $clog2(FRAME_BYTES),
	localparam int CNT_W      = $clog2(FRAME_BYTES + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	dsf_rx_if.sink                      rx,
	output logic                        push,
	output dsf_pkg::frame_desc_t        desc,
	input  wire dsf_pkg::bank_rel_t     rel,
	output logic                        we,
	output logic [IW:0]                 waddr,
	output logic [7:0]                  wdata
);

	logic [CNT_W-1:0]             count_q;
	logic [1:0]                   run_q;
	logic                         ovf_q;
	logic                         bank_q;
	logic [1:0]                   busy_q;
	logic [7:0]                   code_q;

	logic                         acc;
	logic                         store;
	logic                         ovf_n;
	logic [CNT_W-1:0]             cnt_n;
	logic                         is_end;
	logic                         frame_end;
	logic [CNT_W-1:0]             plen_w;
	logic [dsf_pkg::LEN_W-1:0]    plen;
	logic [1:0]                   busy_set;
	logic [1:0]                   busy_clr;

	// the bank being filled must not still be read by the back end
	assign rx.ready  = !busy_q[bank_q];
	assign acc       = rx.valid && rx.ready;

	assign store     = !ovf_q && (count_q < CNT_W'(FRAME_BYTES));
	assign ovf_n     = ovf_q || !store;
	assign cnt_n     = count_q + CNT_W'(store);
	assign is_end    = (rx.rx_byte == dsf_pkg::END_BYTE);
	assign frame_end = is_end && (run_q == 2'(dsf_pkg::END_RUN - 1));
	assign plen_w    = cnt_n - CNT_W'(dsf_pkg::END_RUN);
	assign plen      = dsf_pkg::LEN_W'(plen_w);

	assign push = acc && frame_end && !ovf_n && (cnt_n > CNT_W'(dsf_pkg::END_RUN));

	always_comb begin
		desc.bank   = bank_q;
		desc.code   = code_q;
		desc.kind   = dsf_pkg::classify(code_q, plen);
		desc.dlen   = plen - dsf_pkg::LEN_W'(1);
		desc.ack_ok = (desc.kind == dsf_pkg::KIND_ACK) && (code_q == dsf_pkg::CODE_ACK_OK);
	end

	assign we    = acc && store;
	assign waddr = {bank_q, count_q[IW-1:0]};
	assign wdata = rx.rx_byte;

	assign busy_set = push ? (bank_q ? 2'b10 : 2'b01) : 2'b00;
	assign busy_clr = rel.valid ? (rel.bank ? 2'b10 : 2'b01) : 2'b00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			run_q   <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= 1'b0;
			busy_q  <= '0;
		end else begin
			busy_q <= (busy_q & ~busy_clr) | busy_set;
			if (acc) begin
				if (frame_end) begin
					count_q <= '0;
					run_q   <= '0;
					ovf_q   <= 1'b0;
					if (push) begin
						bank_q <= !bank_q;
					end
				end else begin
					count_q <= cnt_n;
					run_q   <= is_end ? run_q + 2'd1 : 2'd0;
					ovf_q   <= ovf_n;
				end
			end
		end
	end

	// code byte kept aside so the back end needs no read for it
	always_ff @(posedge clk) begin
		if (acc && store && (count_q == '0)) begin
			code_q <= rx.rx_byte;
		end
	end

	`DSF_ASSERT(a_rel_busy, rel.valid |-> busy_q[rel.bank], "release of a bank not in use")
	`DSF_ASSERT_NEXT(a_push_toggle, push, bank_q != $past(bank_q) && busy_q[$past(bank_q)], "push did not hand over bank")

endmodule

`default_nettype wire

@@ rtl/core/dsf_fifo.sv @@
// Two-entry descriptor queue between front and back end.
// Uses dsf_pkg for the descriptor type.
`default_nettype none
`include "assert_macros.svh"

module dsf_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire dsf_pkg::frame_desc_t push_desc,
	input  wire logic                 pop,
	output dsf_pkg::frame_desc_t      head,
	output logic                      empty
);

	dsf_pkg::frame_desc_t ent_q [2];
	logic                 wp_q;
	logic                 rp_q;
	logic [1:0]           cnt_q;
	logic                 full;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_desc;
		end
	end

	`DSF_ASSERT(a_no_overrun, push |-> !full, "descriptor push into full queue")
	`DSF_ASSERT(a_no_underrun, pop |-> !empty, "descriptor pop from empty queue")

endmodule

`default_nettype wire

@@ rtl/core/dsf_back.sv @@
// Back end: walks the data bytes of one frame out of the buffer and drives
// the registered result channel. Uses dsf_pkg.
`default_nettype none
`include "assert_macros.svh"

module dsf_back #(
	parameter int FRAME_BYTES = dsf_pkg::FRAME_BYTES_DEF,
	localparam int IW         = $clog2(FRAME_BYTES)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dsf_pkg::frame_desc_t head,
	input  wire logic                 empty,
	output logic                      pop,
	output logic                      re,
	output logic [IW:0]               raddr,
	input  wire logic [7:0]           rdata,
	output dsf_pkg::bank_rel_t        rel,
	dsf_res_if.source                 res
);

	localparam int LW = dsf_pkg::LEN_W;

	dsf_pkg::back_state_t state_q, state_n;
	dsf_pkg::frame_desc_t cur_q;
	logic [LW-1:0]        idx_q;
	logic [LW:0]          idx_inc;
	logic                 out_free;
	logic                 is_last;
	logic                 load_empty;
	logic                 load_data;

	logic                 out_valid_q;
	logic [7:0]           code_q;
	dsf_pkg::frame_kind_t kind_q;
	logic [LW-1:0]        plen_q;
	logic [7:0]           dbyte_q;
	logic [LW-1:0]        didx_q;
	logic                 dvalid_q;
	logic                 ack_q;
	logic                 last_q;

	assign out_free = !out_valid_q || res.ready;
	assign idx_inc  = {1'b0, idx_q} + (LW+1)'(1);
	assign is_last  = (idx_q == cur_q.dlen - LW'(1));
	// data byte i sits right after the code byte
	assign raddr    = {cur_q.bank, IW'(idx_inc)};

	always_comb begin
		state_n    = state_q;
		pop        = 1'b0;
		re         = 1'b0;
		load_empty = 1'b0;
		load_data  = 1'b0;
		rel.valid  = 1'b0;
		rel.bank   = cur_q.bank;
		unique case (state_q)
			dsf_pkg::ST_IDLE: begin
				if (!empty && out_free) begin
					pop = 1'b1;
					if (head.dlen == '0) begin
						load_empty = 1'b1;
						rel.valid  = 1'b1;
						rel.bank   = head.bank;
					end else begin
						state_n = dsf_pkg::ST_READ;
					end
				end
			end
			dsf_pkg::ST_READ: begin
				re      = 1'b1;
				state_n = dsf_pkg::ST_LOAD;
			end
			dsf_pkg::ST_LOAD: begin
				if (out_free) begin
					load_data = 1'b1;
					if (is_last) begin
						rel.valid = 1'b1;
						state_n   = dsf_pkg::ST_IDLE;
					end else begin
						state_n = dsf_pkg::ST_READ;
					end
				end
			end
			default: state_n = dsf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_empty || load_data) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			idx_q <= '0;
		end else if (load_data) begin
			idx_q <= LW'(idx_inc);
		end
		if (load_empty) begin
			code_q   <= head.code;
			kind_q   <= head.kind;
			plen_q   <= '0;
			dbyte_q  <= '0;
			didx_q   <= '0;
			dvalid_q <= 1'b0;
			ack_q    <= head.ack_ok;
			last_q   <= 1'b1;
		end else if (load_data) begin
			code_q   <= cur_q.code;
			kind_q   <= cur_q.kind;
			plen_q   <= cur_q.dlen;
			dbyte_q  <= rdata;
			didx_q   <= idx_q;
			dvalid_q <= 1'b1;
			ack_q    <= cur_q.ack_ok;
			last_q   <= is_last;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.frame_code     = code_q;
	assign res.frame_kind     = kind_q;
	assign res.payload_length = plen_q;
	assign res.data_byte      = dbyte_q;
	assign res.data_index     = didx_q;
	assign res.data_valid     = dvalid_q;
	assign res.ack_success    = ack_q;
	assign res.last           = last_q;

	`DSF_ASSERT(a_last_index, (out_valid_q && dvalid_q) |-> (last_q == (didx_q == plen_q - LW'(1))), "last flag does not match data index")

endmodule

`default_nettype wire

@@ rtl/core/display_serial_frame_deframer_top.sv @@
// Top level of the display serial frame deframer.
// Depends on dsf_pkg, dsf_rx_if, dsf_res_if, dsf_ram, dsf_front, dsf_fifo, dsf_back.
//
// Usage:
//   rx  : one received serial byte per transaction (valid/ready).
//   res : decoded results, one transaction per data byte after the code byte,
//         or one empty result (data_valid low) for a frame with a code only.
//         last marks the final result of a frame.
//   A frame ends with three consecutive 0xFF bytes. Frames with no byte before
//   the terminator, or that ran past FRAME_BYTES stored bytes, give no result.
// Throughput: the front end takes one byte per cycle. Frames alternate between
//   two buffer banks; rx.ready drops only while both banks hold frames still
//   being read out. The back end takes a descriptor in ST_IDLE, then for each
//   result reads the buffer in ST_READ and loads the output register in ST_LOAD;
//   it takes no new descriptor until the frame's last result is loaded.
// Order: the descriptor is queued on the final terminator transaction. Once idle,
//   the back end pops it; a code-only frame loads its empty result in ST_IDLE.
// Reset: arst_n clears all control state at once; the frame buffer needs no
//   clearing pass, only written entries are ever read.
// Stalls: a result waits in the output register while res.ready is low;
//   the back end pauses, the front end keeps taking bytes into its bank.
`default_nettype none

module display_serial_frame_deframer_top #(
	parameter int FRAME_BYTES = dsf_pkg::FRAME_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dsf_rx_if.sink    rx,
	dsf_res_if.source res
);

	localparam int IW = $clog2(FRAME_BYTES);

	logic                 push;
	dsf_pkg::frame_desc_t push_desc;
	dsf_pkg::frame_desc_t head;
	logic                 empty;
	logic                 pop;
	dsf_pkg::bank_rel_t   rel;
	logic                 we;
	logic [IW:0]          waddr;
	logic [7:0]           wdata;
	logic                 re;
	logic [IW:0]          raddr;
	logic [7:0]           rdata;

	dsf_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.push   (push),
		.desc   (push_desc),
		.rel    (rel),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata)
	);

	// two banks of FRAME_BYTES, bank select in the top address bit
	dsf_ram #(.WIDTH(8), .DEPTH(2 << IW)) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	dsf_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	dsf_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.re     (re),
		.raddr  (raddr),
		.rdata  (rdata),
		.rel    (rel),
		.res    (res)
	);

endmodule

`default_nettype wire
